[src/hdtl_pkg.sv]
`timescale 1ns / 1ps

package hdtl_pkg;

    localparam int DIGEST_BYTES = 32;
    localparam int MAX_NODES    = 1024;

    localparam int QUERY_CHARS = 2 * DIGEST_BYTES;
    localparam int DIGEST_W    = 8 * DIGEST_BYTES;
    localparam int POS_W       = $clog2(DIGEST_BYTES);
    localparam int ENTRY_W     = $clog2(MAX_NODES);
    localparam int NODE_W      = $clog2(MAX_NODES + 1);
    localparam int COUNT_W     = $clog2(QUERY_CHARS + 2);
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;
    localparam int UPC_W       = 3;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic [7:0] CHAR_0 = 8'h30;
    localparam logic [7:0] CHAR_9 = 8'h39;
    localparam logic [7:0] CHAR_A = 8'h61;
    localparam logic [7:0] CHAR_F = 8'h66;

    localparam logic [ADDR_W-1:0] REG_NODE_COUNT = 3'd0;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_MALFORMED = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        UOP_NOP,
        UOP_SETUP,
        UOP_READ,
        UOP_SCAN,
        UOP_EMIT
    } uop_t;

    typedef enum logic [2:0] {
        JC_ALWAYS,
        JC_LAST,
        JC_MALFORMED,
        JC_SCAN_DONE,
        JC_OUT_FREE
    } jcond_t;

    typedef struct packed {
        logic             in_ready;
        uop_t             uop;
        jcond_t           jc;
        logic             hold;
        logic [UPC_W-1:0] target;
    } ctrl_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] nib;
    } hex_t;

    localparam logic [UPC_W-1:0] STEP_WAIT  = 3'd0;
    localparam logic [UPC_W-1:0] STEP_SETUP = 3'd1;
    localparam logic [UPC_W-1:0] STEP_PRIME = 3'd2;
    localparam logic [UPC_W-1:0] STEP_SCAN  = 3'd3;
    localparam logic [UPC_W-1:0] STEP_EMIT  = 3'd4;

    function automatic ctrl_t ucode_word(logic [UPC_W-1:0] upc);
        ctrl_t w;
        w = '{in_ready: 1'b0, uop: UOP_NOP, jc: JC_ALWAYS, hold: 1'b0, target: STEP_WAIT};
        case (upc)
            STEP_WAIT:
            begin
                w = '{in_ready: 1'b1, uop: UOP_NOP, jc: JC_LAST, hold: 1'b1,
                      target: STEP_SETUP};
            end
            STEP_SETUP:
            begin
                w = '{in_ready: 1'b0, uop: UOP_SETUP, jc: JC_MALFORMED, hold: 1'b0,
                      target: STEP_EMIT};
            end
            STEP_PRIME:
            begin
                w = '{in_ready: 1'b0, uop: UOP_READ, jc: JC_ALWAYS, hold: 1'b0,
                      target: STEP_SCAN};
            end
            STEP_SCAN:
            begin
                w = '{in_ready: 1'b0, uop: UOP_SCAN, jc: JC_SCAN_DONE, hold: 1'b1,
                      target: STEP_EMIT};
            end
            STEP_EMIT:
            begin
                w = '{in_ready: 1'b0, uop: UOP_EMIT, jc: JC_OUT_FREE, hold: 1'b1,
                      target: STEP_WAIT};
            end
            default:
            begin
                w = '{in_ready: 1'b0, uop: UOP_NOP, jc: JC_ALWAYS, hold: 1'b0,
                      target: STEP_WAIT};
            end
        endcase
        return w;
    endfunction

    function automatic hex_t decode_hex(logic [7:0] ch);
        hex_t r;
        r.ok  = 1'b1;
        r.nib = 4'd0;
        if (ch inside {[CHAR_0:CHAR_9]})
        begin
            r.nib = 4'(ch - CHAR_0);
        end
        else if (ch inside {[CHAR_A:CHAR_F]})
        begin
            r.nib = 4'(ch - CHAR_A + 8'd10);
        end
        else
        begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage

[src/hdtl_if.sv]
`timescale 1ns / 1ps

interface hdtl_item_if;
    logic                        valid;
    logic                        ready;
    logic                        mode;
    logic [hdtl_pkg::ENTRY_W-1:0] entry_index;
    logic [hdtl_pkg::POS_W-1:0]   byte_position;
    logic [7:0]                  load_byte;
    logic [7:0]                  query_char;
    logic                        query_last;

    modport source (
        output valid, mode, entry_index, byte_position, load_byte, query_char, query_last,
        input  ready
    );
    modport sink (
        input  valid, mode, entry_index, byte_position, load_byte, query_char, query_last,
        output ready
    );
endinterface

interface hdtl_result_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  status;
    logic [hdtl_pkg::NODE_W-1:0]  node_index;
    logic                        found;

    modport source (
        output valid, status, node_index, found,
        input  ready
    );
    modport sink (
        input  valid, status, node_index, found,
        output ready
    );
endinterface

[src/hex_digest_table_lookup_unit.sv]
`timescale 1ns / 1ps

// Channel   Direction  Protocol        Transaction
// item      sink       valid/ready     one table byte load or one query character
// result    source     valid/ready     status, node_index, found per finished query
// apb       slave      APB write/read  node_count at byte address 0
//
// A load transaction or a query character that is not the last leaves the input ready;
// the last query character starts a search that reads rows from entry 0 up to the
// matching node or the node count, and the table memory delivers one 256-bit row per
// cycle. A malformed query or an empty table skips the reads and goes to the output.
// rst_n clears control state and the query buffer; the digest table is not cleared.
// A finished result waits in an output register while new transactions are taken,
// and the next result step stalls until that register has been read.

module hex_digest_table_lookup_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    hdtl_item_if.sink                      item,
    hdtl_result_if.source                  result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hdtl_pkg::ADDR_W-1:0]    paddr,
    input  logic [hdtl_pkg::DATA_W-1:0]    pwdata,
    output logic [hdtl_pkg::DATA_W-1:0]    prdata,
    output logic                           pready
);

    logic [hdtl_pkg::UPC_W-1:0]    upc_reg, upc_next;
    hdtl_pkg::ctrl_t               ctrl;
    logic                          jump;

    logic [hdtl_pkg::NODE_W-1:0]   node_count_reg, node_count_next;
    logic [hdtl_pkg::NODE_W-1:0]   limit;

    logic [hdtl_pkg::DIGEST_W-1:0] query_digest_reg, query_digest_next;
    logic [hdtl_pkg::COUNT_W-1:0]  char_count_reg, char_count_next;
    logic [3:0]                    high_nibble_reg, high_nibble_next;
    logic                          bad_char_reg, bad_char_next;
    hdtl_pkg::hex_t                hex;

    logic [hdtl_pkg::NODE_W-1:0]   issue_reg, issue_next;
    hdtl_pkg::status_t             status_reg, status_next;
    logic [hdtl_pkg::NODE_W-1:0]   hit_index_reg, hit_index_next;

    logic [hdtl_pkg::DIGEST_W-1:0] digest_mem [hdtl_pkg::MAX_NODES];
    logic [hdtl_pkg::DIGEST_W-1:0] rd_data_reg;
    logic                          rd_en;
    logic                          load_we;

    logic                          out_valid_reg, out_valid_next;
    logic [1:0]                    out_status_reg;
    logic [hdtl_pkg::NODE_W-1:0]   out_index_reg;
    logic                          out_found_reg;

    logic                          item_acc;
    logic                          query_acc;
    logic                          last_acc;
    logic                          malformed;
    logic                          match;
    logic                          scan_done;
    logic                          out_free;
    logic                          emit;
    logic                          cfg_we;

    assign ctrl = hdtl_pkg::ucode_word(upc_reg);

    assign item.ready = ctrl.in_ready;
    assign item_acc   = item.valid && ctrl.in_ready;
    assign query_acc  = item_acc && (item.mode == hdtl_pkg::MODE_QUERY);
    assign load_we    = item_acc && (item.mode == hdtl_pkg::MODE_LOAD);
    assign last_acc   = query_acc && item.query_last;

    assign limit = (node_count_reg > hdtl_pkg::NODE_W'(hdtl_pkg::MAX_NODES))
                   ? hdtl_pkg::NODE_W'(hdtl_pkg::MAX_NODES) : node_count_reg;

    assign malformed = bad_char_reg
                       || (char_count_reg != hdtl_pkg::COUNT_W'(hdtl_pkg::QUERY_CHARS));
    assign match     = (rd_data_reg == query_digest_reg);
    assign scan_done = match || (issue_reg == limit);
    assign out_free  = !out_valid_reg || result.ready;
    assign emit      = (ctrl.uop == hdtl_pkg::UOP_EMIT) && out_free;

    assign rd_en = (ctrl.uop == hdtl_pkg::UOP_READ)
                   || ((ctrl.uop == hdtl_pkg::UOP_SCAN) && !scan_done);

    // Sequencer: conditional jump, otherwise hold or advance.
    always_comb
    begin
        case (ctrl.jc)
            hdtl_pkg::JC_ALWAYS:    jump = 1'b1;
            hdtl_pkg::JC_LAST:      jump = last_acc;
            hdtl_pkg::JC_MALFORMED: jump = malformed || (limit == '0);
            hdtl_pkg::JC_SCAN_DONE: jump = scan_done;
            hdtl_pkg::JC_OUT_FREE:  jump = out_free;
            default:                jump = 1'b1;
        endcase
        if (jump)
        begin
            upc_next = ctrl.target;
        end
        else if (ctrl.hold)
        begin
            upc_next = upc_reg;
        end
        else
        begin
            upc_next = upc_reg + 1'b1;
        end
    end

    assign hex = hdtl_pkg::decode_hex(item.query_char);

    always_comb
    begin
        query_digest_next = query_digest_reg;
        char_count_next   = char_count_reg;
        high_nibble_next  = high_nibble_reg;
        bad_char_next     = bad_char_reg;
        if (query_acc)
        begin
            if (!hex.ok)
            begin
                bad_char_next = 1'b1;
            end
            if (char_count_reg < hdtl_pkg::COUNT_W'(hdtl_pkg::QUERY_CHARS))
            begin
                if (!char_count_reg[0])
                begin
                    high_nibble_next = hex.nib;
                end
                else
                begin
                    query_digest_next[{char_count_reg[hdtl_pkg::POS_W:1], 3'b000} +: 8] =
                        {high_nibble_reg, hex.nib};
                end
            end
            if (char_count_reg <= hdtl_pkg::COUNT_W'(hdtl_pkg::QUERY_CHARS))
            begin
                char_count_next = char_count_reg + 1'b1;
            end
        end
        if (emit)
        begin
            query_digest_next = '0;
            char_count_next   = '0;
            high_nibble_next  = '0;
            bad_char_next     = 1'b0;
        end
    end

    always_comb
    begin
        issue_next     = issue_reg;
        status_next    = status_reg;
        hit_index_next = hit_index_reg;
        case (ctrl.uop)
            hdtl_pkg::UOP_SETUP:
            begin
                issue_next     = '0;
                hit_index_next = '0;
                status_next    = malformed ? hdtl_pkg::ST_MALFORMED : hdtl_pkg::ST_NOT_FOUND;
            end
            hdtl_pkg::UOP_SCAN:
            begin
                if (match)
                begin
                    status_next    = hdtl_pkg::ST_FOUND;
                    hit_index_next = issue_reg;
                end
            end
            default:
            begin
            end
        endcase
        if (rd_en)
        begin
            issue_next = issue_reg + 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    assign cfg_we          = psel && penable && pwrite && pready;
    assign node_count_next = (cfg_we && (paddr[2] == hdtl_pkg::REG_NODE_COUNT[2]))
                             ? pwdata[hdtl_pkg::NODE_W-1:0] : node_count_reg;
    assign pready          = 1'b1;
    assign prdata          = (paddr[2] == hdtl_pkg::REG_NODE_COUNT[2])
                             ? hdtl_pkg::DATA_W'(node_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg          <= hdtl_pkg::STEP_WAIT;
            node_count_reg   <= '0;
            query_digest_reg <= '0;
            char_count_reg   <= '0;
            high_nibble_reg  <= '0;
            bad_char_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            upc_reg          <= upc_next;
            node_count_reg   <= node_count_next;
            query_digest_reg <= query_digest_next;
            char_count_reg   <= char_count_next;
            high_nibble_reg  <= high_nibble_next;
            bad_char_reg     <= bad_char_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        issue_reg     <= issue_next;
        status_reg    <= status_next;
        hit_index_reg <= hit_index_next;
        if (emit)
        begin
            out_status_reg <= status_reg;
            out_index_reg  <= hit_index_reg;
            out_found_reg  <= (status_reg == hdtl_pkg::ST_FOUND);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            digest_mem[item.entry_index][{item.byte_position, 3'b000} +: 8] <= item.load_byte;
        end
        if (rd_en)
        begin
            rd_data_reg <= digest_mem[issue_reg[hdtl_pkg::ENTRY_W-1:0]];
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.status     = out_status_reg;
    assign result.node_index = out_index_reg;
    assign result.found      = out_found_reg;

endmodule

[src/hdtl_checker.sv]
`timescale 1ns / 1ps

module hdtl_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          in_mode,
    input logic                          in_last,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [1:0]                    status,
    input logic [hdtl_pkg::NODE_W-1:0]   node_index,
    input logic                          found
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
                                    && $stable(node_index) && $stable(found))
        else $error("Result transaction changed while stalled.");

    a_found_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (found == (status == hdtl_pkg::ST_FOUND))
                      && (found == (node_index != '0)))
        else $error("Found flag disagrees with status or node index.");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> node_index <= hdtl_pkg::NODE_W'(hdtl_pkg::MAX_NODES))
        else $error("Node index exceeds the table size.");

    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_mode == hdtl_pkg::MODE_QUERY) && in_last |=> !in_ready)
        else $error("Input accepted while a search is pending.");

endmodule

bind hex_digest_table_lookup_unit hdtl_checker u_hdtl_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (item.valid),
    .in_ready   (item.ready),
    .in_mode    (item.mode),
    .in_last    (item.query_last),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .status     (result.status),
    .node_index (result.node_index),
    .found      (result.found)
);
